// ===== rtl/hse_pkg.sv =====
// shared types and constants of the heap sort engine
`default_nettype none

package hse_pkg;

    // default configuration
    localparam int DEPTH_DEFAULT       = 16;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // width of the value fields on the ports
    localparam int DATA_W = 32;

    // one input item
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last_in;
    } hse_in_t;

    // one result item
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     last_out;
        logic                     overflow;
    } hse_out_t;

endpackage

`default_nettype wire

// ===== rtl/hse_store.sv =====
// element store: single write port, single read port, registered read data
`default_nettype none

module hse_store
    import hse_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic                   clk,
    input  wire logic                   wr_en,
    input  wire logic [AW-1:0]          wr_addr,
    input  wire logic [VALUE_WIDTH-1:0] wr_data,
    input  wire logic                   rd_en,
    input  wire logic [AW-1:0]          rd_addr,
    output      logic [VALUE_WIDTH-1:0] rd_data
);

    logic [VALUE_WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, read data registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/heap_sort_engine_core.sv =====
// heap sort engine top level: load, in-place heapsort, ascending emission
//
// Input items arrive on start/item and are accepted at a rising edge with
// start high and busy low. Each item's value is written into the element
// store as it is accepted. Items beyond DEPTH are dropped and mark the
// batch as overflowed. An item with last_in ends the batch and starts the
// sort; busy stays high until the final result has been read out.
// The sort builds a max-heap and then extracts the root repeatedly. All
// heap state sits in one single-port-read synchronous memory; each sift
// level takes a left child read, a right child read and a compare and
// write back. Results leave on result_valid/result, one cycle each, in
// consecutive cycles. The receiver cannot stall: every strobed result
// is taken.
// After reset the store is empty, no batch is pending and busy is low.

`default_nettype none

module heap_sort_engine_core
    import hse_pkg::*;
#(
    parameter int DEPTH       = DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output      logic     busy,
    input  wire hse_in_t  item,
    output      logic     result_valid,
    output      hse_out_t result
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = CW + 1;
    localparam int VW = VALUE_WIDTH;

    localparam logic [3:0] S_LOAD    = 4'd0;
    localparam logic [3:0] S_BUILD   = 4'd1;
    localparam logic [3:0] S_CURWAIT = 4'd2;
    localparam logic [3:0] S_SIFT    = 4'd3;
    localparam logic [3:0] S_LEFT    = 4'd4;
    localparam logic [3:0] S_RIGHT   = 4'd5;
    localparam logic [3:0] S_EXTRACT = 4'd6;
    localparam logic [3:0] S_XROOT   = 4'd7;
    localparam logic [3:0] S_XLAST   = 4'd8;
    localparam logic [3:0] S_EMIT    = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [CW-1:0]        count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic                 phase_reg, phase_next;
    logic [CW-1:0]        k_reg, k_next;
    logic [CW-1:0]        end_reg, end_next;
    logic [IW-1:0]        pos_reg, pos_next;
    logic [CW-1:0]        emit_reg, emit_next;
    logic signed [VW-1:0] cur_reg, cur_next;
    logic signed [VW-1:0] lch_reg, lch_next;
    logic                 valid_reg;
    logic                 last_reg, last_next;
    logic                 ovf_reg, ovf_next;

    logic                 rd_en, wr_en;
    logic [IW-1:0]        rd_idx, wr_idx;
    logic [IW-1:0]        rd_off, wr_off;
    logic [VW-1:0]        wr_data;
    logic [VW-1:0]        rd_data;
    logic signed [VW-1:0] rd_val;

    logic [IW-1:0]        child;
    logic [IW-1:0]        child_r;
    logic [IW-1:0]        end_ext;
    logic                 store_full;
    logic [CW-1:0]        count_fill;
    logic signed [VW-1:0] big_val;
    logic [IW-1:0]        big_idx;

    // heap indices are one-based, store addresses zero-based
    assign rd_off = rd_idx - IW'(1);
    assign wr_off = wr_idx - IW'(1);

    hse_store #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_off[AW-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_off[AW-1:0]),
        .rd_data (rd_data)
    );

    assign rd_val     = $signed(rd_data);
    assign child      = pos_reg << 1;
    assign child_r    = child + IW'(1);
    assign end_ext    = IW'(end_reg);
    assign store_full = (count_reg == CW'(DEPTH));
    assign count_fill = store_full ? count_reg : count_reg + CW'(1);

    // larger child, left kept on a tie
    always_comb
    begin
        if (lch_reg < rd_val)
        begin
            big_val = rd_val;
            big_idx = child_r;
        end
        else
        begin
            big_val = lch_reg;
            big_idx = child;
        end
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        phase_next   = phase_reg;
        k_next       = k_reg;
        end_next     = end_reg;
        pos_next     = pos_reg;
        emit_next    = emit_reg;
        cur_next     = cur_reg;
        lch_next     = lch_reg;
        last_next    = last_reg;
        ovf_next     = ovf_reg;
        rd_en        = 1'b0;
        rd_idx       = IW'(1);
        wr_en        = 1'b0;
        wr_idx       = pos_reg;
        wr_data      = cur_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (start)
                begin
                    if (!store_full)
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = IW'(count_reg) + IW'(1);
                        wr_data    = VW'(item.value);
                        count_next = count_reg + CW'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (item.last_in)
                    begin
                        k_next     = count_fill >> 1;
                        phase_next = 1'b0;
                        state_next = S_BUILD;
                    end
                end
            end

            S_BUILD:
            begin
                if (k_reg == '0)
                begin
                    k_next     = count_reg;
                    phase_next = 1'b1;
                    state_next = S_EXTRACT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = IW'(k_reg);
                    pos_next   = IW'(k_reg);
                    end_next   = count_reg;
                    state_next = S_CURWAIT;
                end
            end

            S_CURWAIT:
            begin
                cur_next   = rd_val;
                state_next = S_SIFT;
            end

            S_SIFT:
            begin
                if (child > end_ext)
                begin
                    wr_en      = 1'b1;
                    k_next     = k_reg - CW'(1);
                    state_next = phase_reg ? S_EXTRACT : S_BUILD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = child;
                    state_next = S_LEFT;
                end
            end

            S_LEFT:
            begin
                lch_next = rd_val;
                if (child_r <= end_ext)
                begin
                    rd_en      = 1'b1;
                    rd_idx     = child_r;
                    state_next = S_RIGHT;
                end
                else if (cur_reg < rd_val)
                begin
                    wr_en      = 1'b1;
                    wr_data    = VW'(rd_val);
                    pos_next   = child;
                    state_next = S_SIFT;
                end
                else
                begin
                    wr_en      = 1'b1;
                    k_next     = k_reg - CW'(1);
                    state_next = phase_reg ? S_EXTRACT : S_BUILD;
                end
            end

            S_RIGHT:
            begin
                wr_en = 1'b1;
                if (cur_reg < big_val)
                begin
                    wr_data    = VW'(big_val);
                    pos_next   = big_idx;
                    state_next = S_SIFT;
                end
                else
                begin
                    k_next     = k_reg - CW'(1);
                    state_next = phase_reg ? S_EXTRACT : S_BUILD;
                end
            end

            S_EXTRACT:
            begin
                if (k_reg < CW'(2))
                begin
                    emit_next  = CW'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_idx     = IW'(1);
                    state_next = S_XROOT;
                end
            end

            S_XROOT:
            begin
                lch_next   = rd_val;
                rd_en      = 1'b1;
                rd_idx     = IW'(k_reg);
                state_next = S_XLAST;
            end

            S_XLAST:
            begin
                // old root goes to the last unsorted slot
                cur_next   = rd_val;
                wr_en      = 1'b1;
                wr_idx     = IW'(k_reg);
                wr_data    = VW'(lch_reg);
                pos_next   = IW'(1);
                end_next   = k_reg - CW'(1);
                state_next = S_SIFT;
            end

            S_EMIT:
            begin
                rd_en     = 1'b1;
                rd_idx    = IW'(emit_reg);
                last_next = (emit_reg == count_reg);
                ovf_next  = dropped_reg;
                if (emit_reg == count_reg)
                begin
                    count_next   = '0;
                    dropped_next = 1'b0;
                    state_next   = S_LOAD;
                end
                else
                begin
                    emit_next = emit_reg + CW'(1);
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            phase_reg   <= 1'b0;
            k_reg       <= '0;
            end_reg     <= '0;
            pos_reg     <= '0;
            emit_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            phase_reg   <= phase_next;
            k_reg       <= k_next;
            end_reg     <= end_next;
            pos_reg     <= pos_next;
            emit_reg    <= emit_next;
            valid_reg   <= (state_reg == S_EMIT);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        lch_reg  <= lch_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

    // outputs
    assign busy                = (state_reg != S_LOAD);
    assign result_valid        = valid_reg;
    assign result.sorted_value = DATA_W'(rd_data);
    assign result.last_out     = last_reg;
    assign result.overflow     = ovf_reg;

    // results of one batch leave in consecutive cycles
    a_results_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last_out) |=> result_valid)
        else $error("gap inside a batch of results");

    // nothing follows the final result directly
    a_last_ends_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last_out) |=> !result_valid)
        else $error("result directly after last_out");

    // a last item starts the sort
    a_last_starts_sort: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.last_in) |=> (busy && state_reg == S_BUILD))
        else $error("sort not started by last item");

    // read-out index stays within the batch
    a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (emit_reg >= CW'(1) && emit_reg <= count_reg))
        else $error("read-out index out of range");

    // sift position never leaves the live heap
    a_sift_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SIFT) |-> (pos_reg >= IW'(1) && pos_reg <= end_ext))
        else $error("sift position outside the heap");

endmodule

`default_nettype wire

// ===== test/sorted_order_checker.sv =====
// checker for the heap sort engine: watches both channels, predicts the sorted output
`default_nettype none

module sorted_order_checker
    import hse_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire hse_in_t item,
    input  wire logic result_valid,
    input  wire hse_out_t result,
    output int        fail_count,
    output int        pending,
    output int        results_seen
);

    // own copy of the heap store and batch state
    logic signed [DATA_W-1:0] heap_store [1:DEPTH];
    int                       held;
    bit                       dropped;
    hse_out_t                 ascending_q [$];
    int                       errors;
    int                       seen;

    task automatic swap_slots(input int a, input int b);
        logic signed [DATA_W-1:0] tmp;
        tmp           = heap_store[a];
        heap_store[a] = heap_store[b];
        heap_store[b] = tmp;
    endtask

    // sift-down: larger child wins, left kept on a tie, stop once parent is not smaller
    task automatic sift_down(input int top, input int bound);
        int parent;
        int child;
        bit done;
        parent = top;
        child  = 2 * top;
        done   = 1'b0;
        while (!done && child <= bound)
        begin
            if (child + 1 <= bound && heap_store[child] < heap_store[child + 1])
                child++;
            if (!(heap_store[parent] < heap_store[child]))
                done = 1'b1;
            else
            begin
                swap_slots(parent, child);
                parent = child;
                child  = 2 * parent;
            end
        end
    endtask

    // heapsort the held elements and queue them in ascending order
    task automatic heapsort_batch();
        hse_out_t exp_item;
        for (int k = held / 2; k >= 1; k--)
            sift_down(k, held);
        for (int k = held; k >= 2; k--)
        begin
            swap_slots(1, k);
            sift_down(1, k - 1);
        end
        for (int k = 1; k <= held; k++)
        begin
            exp_item.sorted_value = heap_store[k];
            exp_item.last_out     = (k == held);
            exp_item.overflow     = dropped;
            ascending_q.push_back(exp_item);
        end
        held    = 0;
        dropped = 1'b0;
    endtask

    // take one accepted item into the batch
    task automatic absorb_item(input hse_in_t it);
        if (held < DEPTH)
        begin
            held++;
            heap_store[held] = it.value;
        end
        else
            dropped = 1'b1;
        if (it.last_in)
            heapsort_batch();
    endtask

    // compare one result with the oldest expectation
    task automatic check_result(input hse_out_t got);
        hse_out_t want;
        seen++;
        if (ascending_q.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result value %0d last %0b overflow %0b",
                     $time, got.sorted_value, got.last_out, got.overflow);
        end
        else
        begin
            want = ascending_q.pop_front();
            if (got.sorted_value !== want.sorted_value)
            begin
                errors++;
                $display("%0t: sorted_value expected %0d actual %0d",
                         $time, want.sorted_value, got.sorted_value);
            end
            if (got.last_out !== want.last_out)
            begin
                errors++;
                $display("%0t: last_out expected %0b actual %0b",
                         $time, want.last_out, got.last_out);
            end
            if (got.overflow !== want.overflow)
            begin
                errors++;
                $display("%0t: overflow expected %0b actual %0b",
                         $time, want.overflow, got.overflow);
            end
        end
    endtask

    // sample both channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held    = 0;
            dropped = 1'b0;
            errors  = 0;
            seen    = 0;
            ascending_q.delete();
            fail_count   <= 0;
            pending      <= 0;
            results_seen <= 0;
        end
        else
        begin
            if (result_valid)
                check_result(result);
            if (start && !busy)
                absorb_item(item);
            fail_count   <= errors;
            pending      <= ascending_q.size();
            results_seen <= seen;
        end
    end

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// top of the heap sort engine testbench: clock, reset, batch stimulus and verdict
`default_nettype none

module testbench
    import hse_pkg::*;
();

    localparam int DEPTH      = DEPTH_DEFAULT;
    localparam int QUIET_MAX  = 5000;
    localparam int ITEM_GOAL  = 430;

    // value flavours for a batch
    typedef enum int { VAL_RANDOM, VAL_NARROW, VAL_EXTREME } value_mode_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    hse_in_t  item;
    logic     result_valid;
    hse_out_t result;

    int fail_count;
    int pending;
    int results_seen;
    int items_sent;
    int batches_sent;
    int overflow_batches;
    int quiet_cycles;

    heap_sort_engine_core dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result)
    );

    sorted_order_checker #(.DEPTH(DEPTH)) u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on cycles with no traffic on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_MAX)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [DATA_W-1:0] pick_value(input value_mode_t mode);
        logic [DATA_W-1:0] v;
        case (mode)
            VAL_NARROW:  v = DATA_W'($signed($urandom_range(0, 6)) - 3);
            VAL_EXTREME:
                case ($urandom_range(0, 4))
                    0:       v = {1'b0, {(DATA_W-1){1'b1}}};
                    1:       v = {1'b1, {(DATA_W-1){1'b0}}};
                    2:       v = '0;
                    3:       v = '1;
                    default: v = DATA_W'(1);
                endcase
            default:     v = $urandom;
        endcase
        return v;
    endfunction

    // random idle cycles on the sender, none inside the quiet stretch
    task automatic sender_gaps();
        if (items_sent >= 150 && items_sent < 260)
            return;
        while ($urandom_range(0, 99) < 36)
        begin
            @(negedge clk);
            start = 1'b0;
            item  = {DATA_W'($urandom), 1'($urandom)};
        end
    endtask

    // present one item and hold it until accepted
    task automatic send_item(input logic [DATA_W-1:0] v, input logic last);
        sender_gaps();
        @(negedge clk);
        start        = 1'b1;
        item.value   = v;
        item.last_in = last;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
    endtask

    task automatic send_batch(input int size, input value_mode_t mode);
        for (int i = 1; i <= size; i++)
            send_item(pick_value(mode), i == size);
        batches_sent++;
        if (size > DEPTH)
            overflow_batches++;
    endtask

    // stimulus
    initial
    begin
        logic [DATA_W-1:0] edge_vals [8];
        int                size;
        value_mode_t       mode;

        rst_n            = 1'b0;
        start            = 1'b0;
        item             = '0;
        items_sent       = 0;
        batches_sent     = 0;
        overflow_batches = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single element batch at the most negative value
        send_item({1'b1, {(DATA_W-1){1'b0}}}, 1'b1);
        batches_sent++;

        // extremes with repeated values to exercise the tie rule
        edge_vals = '{{1'b0, {(DATA_W-1){1'b1}}}, {1'b1, {(DATA_W-1){1'b0}}}, '0, '1,
                      DATA_W'(1), {1'b0, {(DATA_W-1){1'b1}}}, {1'b1, {(DATA_W-1){1'b0}}}, '1};
        for (int i = 0; i < 8; i++)
            send_item(edge_vals[i], i == 7);
        batches_sent++;

        // store full, the closing item itself is dropped
        send_batch(DEPTH + 1, VAL_RANDOM);

        // random batches, mostly within depth, some overflowing
        while (items_sent < ITEM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0:       size = $urandom_range(DEPTH + 1, DEPTH + 4);
                1:       size = DEPTH;
                2:       size = 1;
                default: size = $urandom_range(2, DEPTH);
            endcase
            case ($urandom_range(0, 5))
                0:       mode = VAL_NARROW;
                1:       mode = VAL_EXTREME;
                default: mode = VAL_RANDOM;
            endcase
            send_batch(size, mode);
        end

        @(negedge clk);
        start = 1'b0;

        // drain the outstanding results
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("covered %0d items in %0d batches, %0d of them overflowing the store",
                 items_sent, batches_sent, overflow_batches);
        $display("%0d sorted results compared against the predicted order", results_seen);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
